// ----- design/clns_pkg.sv -----
// clns_pkg: shared types and constants for the character display nibble sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package clns_pkg;

    // Item kinds on the input side; the fourth code carries no meaning
    typedef enum logic [1:0] {
        KIND_MESSAGE = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_COMMAND = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [0:0] REG_CLEAR_BEFORE_WRITE = 1'b0;
    localparam logic [0:0] REG_LINE_SEPARATOR     = 1'b1;

    localparam logic [7:0] LINE_SEP_RESET = 8'd43;

    // Display commands
    localparam logic [7:0] CMD_DDRAM_SET = 8'h80;
    localparam logic [7:0] ROW1_ADDR     = 8'h40;
    localparam logic [7:0] ROW2_ADDR     = 8'h14;
    localparam logic [7:0] ROW3_ADDR     = 8'h54;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;

    localparam logic [7:0] CMD_ROW1 = CMD_DDRAM_SET | ROW1_ADDR;
    localparam logic [7:0] CMD_ROW2 = CMD_DDRAM_SET | ROW2_ADDR;
    localparam logic [7:0] CMD_ROW3 = CMD_DDRAM_SET | ROW3_ADDR;

    // Register select levels
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    localparam int ROW_W = 3;

    // Default depth of the job queue between front and back
    localparam int JOB_DEPTH_DEF = 2;

    // One classified item: up to three bytes, sent in the order clear, body, home
    typedef struct packed {
        logic       has_home;
        logic       has_body;
        logic       has_clear;
        logic       body_rs;
        logic [7:0] body_byte;
    } job_t;

endpackage

`default_nettype wire

// ----- design/clns_front.sv -----
// clns_front: accepts input items, tracks message state, builds byte jobs.
// Holds the configuration registers. Depends on clns_pkg.
`default_nettype none

module clns_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          kind,
    input  wire logic [7:0]          byte_value,
    input  wire logic                message_end,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [7:0]          cfg_data,
    output logic                     job_push,
    output clns_pkg::job_t           job,
    input  wire logic                job_full
);
    import clns_pkg::*;

    logic             clear_cfg_reg;
    logic [7:0]       sep_cfg_reg;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic             in_message_reg, in_message_next;
    logic             dropping_reg, dropping_next;

    logic             accept;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] row_inc;
    logic             drop_cur;
    job_t             job_w;

    assign full      = job_full;
    assign cfg_ready = 1'b1;
    assign accept    = push && !job_full;

    always_comb
    begin
        job_w           = '0;
        row_count_next  = row_count_reg;
        in_message_next = in_message_reg;
        dropping_next   = dropping_reg;
        row_cur         = in_message_reg ? row_count_reg : '0;
        drop_cur        = in_message_reg ? dropping_reg : 1'b0;
        row_inc         = row_cur + ROW_W'(1);

        unique case (kind)
            KIND_DATA:
            begin
                job_w.has_body  = 1'b1;
                job_w.body_rs   = RS_DATA;
                job_w.body_byte = byte_value;
            end
            KIND_COMMAND:
            begin
                job_w.has_body  = 1'b1;
                job_w.body_rs   = RS_COMMAND;
                job_w.body_byte = byte_value;
            end
            KIND_MESSAGE:
            begin
                job_w.has_clear = !in_message_reg && clear_cfg_reg;
                row_count_next  = row_cur;
                dropping_next   = drop_cur;
                in_message_next = 1'b1;
                if (!drop_cur)
                begin
                    priority if (byte_value == 8'd0)
                    begin
                        dropping_next = 1'b1;
                    end
                    else if (byte_value == sep_cfg_reg)
                    begin
                        row_count_next  = row_inc;
                        job_w.body_rs   = RS_COMMAND;
                        priority if (row_inc == ROW_W'(1))
                        begin
                            job_w.has_body  = 1'b1;
                            job_w.body_byte = CMD_ROW1;
                        end
                        else if (row_inc == ROW_W'(2))
                        begin
                            job_w.has_body  = 1'b1;
                            job_w.body_byte = CMD_ROW2;
                        end
                        else if (row_inc == ROW_W'(3))
                        begin
                            job_w.has_body  = 1'b1;
                            job_w.body_byte = CMD_ROW3;
                        end
                        else
                        begin
                            dropping_next = 1'b1;
                        end
                    end
                    else
                    begin
                        job_w.has_body  = 1'b1;
                        job_w.body_rs   = RS_DATA;
                        job_w.body_byte = byte_value;
                    end
                end
                if (message_end)
                begin
                    job_w.has_home  = 1'b1;
                    in_message_next = 1'b0;
                    row_count_next  = '0;
                    dropping_next   = 1'b0;
                end
            end
            default:
            begin
                // meaningless kind: ignored
            end
        endcase
    end

    assign job      = job_w;
    assign job_push = accept && (job_w.has_clear || job_w.has_body || job_w.has_home);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cfg_reg  <= 1'b0;
            sep_cfg_reg    <= LINE_SEP_RESET;
            row_count_reg  <= '0;
            in_message_reg <= 1'b0;
            dropping_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_CLEAR_BEFORE_WRITE: clear_cfg_reg <= cfg_data[0];
                    REG_LINE_SEPARATOR:     sep_cfg_reg   <= cfg_data;
                    default:                ;
                endcase
            end
            if (accept)
            begin
                row_count_reg  <= row_count_next;
                in_message_reg <= in_message_next;
                dropping_reg   <= dropping_next;
            end
        end
    end

    // row count saturates at the fourth separator
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= ROW_W'(4))
        else $error("row count past four");

    // dropping only makes sense inside a message
    a_drop_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> in_message_reg)
        else $error("dropping outside a message");

endmodule

`default_nettype wire

// ----- design/clns_job_fifo.sv -----
// clns_job_fifo: short queue of byte jobs between front and back.
// Depends on clns_pkg for job_t.
`default_nettype none

module clns_job_fifo #(
    parameter int DEPTH = clns_pkg::JOB_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire clns_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output clns_pkg::job_t       head_job
);
    import clns_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // the front must never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

endmodule

`default_nettype wire

// ----- design/clns_back.sv -----
// clns_back: expands one byte job into nibble strobes, one per cycle while the
// one-entry output register it feeds is empty or popped. Depends on clns_pkg.
`default_nettype none

module clns_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire clns_pkg::job_t  job,
    output logic                 job_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic                 register_select,
    output logic [3:0]           nibble,
    output logic                 last_strobe
);
    import clns_pkg::*;

    // mask bit 0 clear, bit 1 body, bit 2 home
    logic [2:0] mask_reg, mask_next;
    logic       half_reg, half_next;
    logic [7:0] body_byte_reg, body_byte_next;
    logic       body_rs_reg, body_rs_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_rs_reg, out_rs_next;
    logic [3:0] out_nib_reg, out_nib_next;
    logic       out_last_reg, out_last_next;

    logic [7:0] cur_byte;
    logic       cur_rs;
    logic [2:0] lowest;
    logic [2:0] mask_after;
    logic       active;
    logic       advance;
    logic       is_last;

    always_comb
    begin
        priority if (mask_reg[0])
        begin
            cur_byte = CMD_CLEAR;
            cur_rs   = RS_COMMAND;
        end
        else if (mask_reg[1])
        begin
            cur_byte = body_byte_reg;
            cur_rs   = body_rs_reg;
        end
        else
        begin
            cur_byte = CMD_HOME;
            cur_rs   = RS_COMMAND;
        end

        lowest     = mask_reg & (~mask_reg + 3'd1);
        mask_after = half_reg ? (mask_reg & ~lowest) : mask_reg;
        active     = (mask_reg != 3'd0);
        advance    = active && (!out_valid_reg || pop);
        is_last    = half_reg && (mask_after == 3'd0);
        job_pop    = job_valid && (!active || (advance && is_last));

        mask_next      = mask_reg;
        half_next      = half_reg;
        body_byte_next = body_byte_reg;
        body_rs_next   = body_rs_reg;
        out_valid_next = out_valid_reg && !pop;
        out_rs_next    = out_rs_reg;
        out_nib_next   = out_nib_reg;
        out_last_next  = out_last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_rs_next    = cur_rs;
            out_nib_next   = half_reg ? cur_byte[3:0] : cur_byte[7:4];
            out_last_next  = is_last;
            mask_next      = mask_after;
            half_next      = !half_reg;
        end
        if (job_pop)
        begin
            mask_next      = {job.has_home, job.has_body, job.has_clear};
            half_next      = 1'b0;
            body_byte_next = job.body_byte;
            body_rs_next   = job.body_rs;
        end
    end

    always_ff @(posedge clk)
    begin
        body_byte_reg <= body_byte_next;
        body_rs_reg   <= body_rs_next;
        out_rs_reg    <= out_rs_next;
        out_nib_reg   <= out_nib_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 3'd0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty           = !out_valid_reg;
    assign register_select = out_rs_reg;
    assign nibble          = out_nib_reg;
    assign last_strobe     = out_last_reg;

    // an idle back end always sits on a high-nibble boundary
    a_idle_half: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg == 3'd0) |-> !half_reg)
        else $error("back end idle mid-byte");

endmodule

`default_nettype wire

// ----- design/char_lcd_message_nibble_sequencer_core.sv -----
// char_lcd_message_nibble_sequencer_core: top level of the 4-bit display bus sequencer.
// Instantiates clns_front, clns_job_fifo and clns_back; depends on clns_pkg.
//
// Usage:
//   Input queue: drive kind/byte_value/message_end and raise push; the item is
//   taken on an edge where push is high and full is low. Kind 0 is a message
//   byte, 1 a raw data byte, 2 a raw command byte; kind 3 is ignored.
//   Result queue: while empty is low, register_select/nibble/last_strobe hold
//   the oldest strobe; pop takes it. last_strobe marks an item's final strobe.
//   Config: cfg_valid/cfg_ready (ready is always high), cfg_index 0 selects
//   clear_before_write, 1 the line separator byte. Write only while idle.
// Timing:
//   An item that sends bytes passes the job queue, the back end load and the
//   output register before its first strobe shows. The back end emits one
//   strobe per cycle while pop keeps the output register free; each byte
//   (clear, body, home) takes two nibbles. Items that send nothing push no
//   job. The front keeps accepting until the job queue is full.
// Reset clears message state, queues and output; config returns to its
// defaults (no clear, separator 43). When pop stays low the output register
// holds its strobe, the back end stalls, and full rises once the queue fills.
`default_nettype none

module char_lcd_message_nibble_sequencer_core #(
    parameter int JOB_DEPTH = clns_pkg::JOB_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  byte_value,
    input  wire logic        message_end,
    output logic             empty,
    input  wire logic        pop,
    output logic             register_select,
    output logic [3:0]       nibble,
    output logic             last_strobe,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import clns_pkg::*;

    // front -> queue
    logic job_push;
    job_t job_in;
    logic job_full;

    // queue -> back
    logic job_valid;
    job_t job_head;
    logic job_pop;

    // front: classification and message state, config registers
    clns_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .byte_value  (byte_value),
        .message_end (message_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .job_push    (job_push),
        .job         (job_in),
        .job_full    (job_full)
    );

    // decouples classification from the slow bus side
    clns_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job_in),
        .full       (job_full),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_job   (job_head)
    );

    // back: nibble strobes, one per cycle while the output is free or popped, into the output register
    clns_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job             (job_head),
        .job_pop         (job_pop),
        .empty           (empty),
        .pop             (pop),
        .register_select (register_select),
        .nibble          (nibble),
        .last_strobe     (last_strobe)
    );

endmodule

`default_nettype wire
